FILE: rtl/core/mlp3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp3_pkg
// Shared types, constants and activation functions of the perceptron block.
// ----------------------------------------------------------------------------
package mlp3_pkg;

    localparam int INPUTS_DEF     = 4;
    localparam int HIDDEN_ONE_DEF = 4;
    localparam int HIDDEN_TWO_DEF = 4;
    localparam int OUTPUTS_DEF    = 3;

    localparam int FEAT_FIELDS  = 4;
    localparam int SCORE_FIELDS = 3;

    typedef enum logic [1:0] {
        ACT_SIGMOID = 2'd0,
        ACT_TANH    = 2'd1,
        ACT_RELU    = 2'd2,
        ACT_LEAKY   = 2'd3
    } t_act;

    typedef enum logic {
        ACTION_LOAD  = 1'b0,
        ACTION_INFER = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_ACT,
        ST_RANK,
        ST_OUT
    } t_state;

    // Piecewise-linear sigmoid on a 17-bit signed value; result 0..256.
    function automatic logic signed [17:0] plan_sigmoid(input logic signed [16:0] x);
        logic [16:0] a;
        logic [17:0] y;
        begin
            a = x[16] ? 17'(-x) : 17'(x);
            if (a >= 17'd1280)     y = 18'd256;
            else if (a >= 17'd608) y = 18'(a >> 5) + 18'd216;
            else if (a >= 17'd256) y = 18'(a >> 3) + 18'd160;
            else                   y = 18'(a >> 2) + 18'd128;
            plan_sigmoid = x[16] ? 18'(18'd256 - y) : y;
        end
    endfunction

    function automatic logic signed [15:0] activate(input logic [1:0] mode,
                                                    input logic signed [15:0] x);
        logic signed [17:0] s;
        logic signed [31:0] p;
        begin
            activate = x;
            case (mode)
                ACT_SIGMOID: begin
                    s = plan_sigmoid(17'(x));
                    activate = 16'(s);
                end
                ACT_TANH: begin
                    s = plan_sigmoid({x, 1'b0});
                    activate = 16'((s <<< 1) - 18'sd256);
                end
                ACT_RELU: activate = (x > 16'sd0) ? x : 16'sd0;
                default: begin
                    p = 32'(x) * 32'sd655 + 32'sd32768;
                    activate = (x > 16'sd0) ? x : 16'(p >>> 16);
                end
            endcase
        end
    endfunction

endpackage

FILE: rtl/core/mlp_three_layer_inference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_three_layer_inference
// Fixed-point 4-4-4-3 perceptron forward pass with a shared MAC.
// ----------------------------------------------------------------------------
// Operation: a load beat is written to the parameter memory as it is accepted;
// an infer beat runs, per neuron, a bias state, a MAC state over its weights and
// an activation state, layer by layer, then a ranking state over the scores and
// an output state; all neurons share the single MAC.
// One item is in flight at a time: no beat is taken until the last result has
// left the output state. Reset (synchronous, active low) clears parameter memory.
module mlp_three_layer_inference #(
    parameter int INPUTS     = mlp3_pkg::INPUTS_DEF,
    parameter int HIDDEN_ONE = mlp3_pkg::HIDDEN_ONE_DEF,
    parameter int HIDDEN_TWO = mlp3_pkg::HIDDEN_TWO_DEF,
    parameter int OUTPUTS    = mlp3_pkg::OUTPUTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,      // act_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: param_index[5:0], param_value[21:6], feature_0..3 [37:22]..[85:70]
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tuser,     // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: score_0[15:0], score_1[31:16], score_2[47:32], best_class[49:48]
    output logic [55:0] m_axis_tdata
);
    // Store layout follows the layer sizes.
    localparam int W2B   = INPUTS * HIDDEN_ONE;
    localparam int W3B   = W2B + HIDDEN_ONE * HIDDEN_TWO;
    localparam int B1B   = W3B + HIDDEN_TWO * OUTPUTS;
    localparam int B2B   = B1B + HIDDEN_ONE;
    localparam int B3B   = B2B + HIDDEN_TWO;
    localparam int DEPTH = B3B + OUTPUTS;
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int LW    = 5;   // up to 16 neurons per layer, count holds 16
    localparam int MAXN  = 16;

    // Parameter memory with registered read.
    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rd;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Layer buffers: source values and destination values.
    logic signed [15:0] r_src [MAXN];
    logic signed [15:0] r_dst [MAXN];

    mlp3_pkg::t_state r_state, n_state;
    logic [1:0]     r_act;
    logic [1:0]     r_layer;
    logic [LW-1:0]  r_nrn;
    logic [LW-1:0]  r_j;
    logic [AW-1:0]  r_wptr;
    logic [AW:0]    r_clr;
    logic signed [39:0] r_acc;
    logic signed [31:0] r_prod;
    logic           r_pv;
    logic [1:0]     r_best;
    logic signed [15:0] r_bval;
    logic [LW-1:0]  r_rk;
    logic [55:0]    r_out;
    logic           r_ovalid;

    logic [LW-1:0] n_in, n_out;
    logic [AW-1:0] b_base;
    logic          clearing;
    logic          load_ok;
    logic signed [39:0] acc_fin;
    logic signed [31:0] shifted;
    logic signed [15:0] sat;

    assign clearing = !r_clr[AW];

    always_comb begin
        case (r_layer)
            2'd0: begin n_in = LW'(INPUTS);     n_out = LW'(HIDDEN_ONE); b_base = AW'(B1B); end
            2'd1: begin n_in = LW'(HIDDEN_ONE); n_out = LW'(HIDDEN_TWO); b_base = AW'(B2B); end
            default: begin
                n_in = LW'(HIDDEN_TWO); n_out = LW'(OUTPUTS); b_base = AW'(B3B);
            end
        endcase
    end

    assign s_axis_tready = (r_state == mlp3_pkg::ST_IDLE) && !clearing;
    assign load_ok = (32'(s_axis_tdata[5:0]) < DEPTH);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_clr[AW-1:0]);
        mem_wd = '0;
        if (clearing) begin
            mem_we = 1'b1;
        end else if (s_axis_tvalid && s_axis_tready &&
                     s_axis_tuser == mlp3_pkg::ACTION_LOAD && load_ok) begin
            mem_we = 1'b1;
            mem_wa = AW'(s_axis_tdata[5:0]);
            mem_wd = s_axis_tdata[21:6];
        end
    end

    // Read address: bias in ST_BIAS, else the running weight pointer.
    always_comb begin
        if (r_state == mlp3_pkg::ST_BIAS) rd_addr = b_base + AW'(r_nrn);
        else                              rd_addr = r_wptr;
    end

    // The final product lands in r_prod the cycle after the last weight reaches r_rd.
    assign acc_fin  = r_acc + (r_pv ? 40'(r_prod) : 40'sd0);
    assign shifted  = 32'(acc_fin >>> 8);
    assign sat = (acc_fin > 40'sd8388607)  ? 16'sh7fff :
                 (acc_fin < -40'sd8388608) ? -16'sh8000 : 16'(shifted);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mlp3_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready &&
                    s_axis_tuser == mlp3_pkg::ACTION_INFER) begin
                    n_state = mlp3_pkg::ST_BIAS;
                end
            mlp3_pkg::ST_BIAS: n_state = mlp3_pkg::ST_MAC;
            mlp3_pkg::ST_MAC:
                if (r_j == n_in) n_state = mlp3_pkg::ST_ACT;
            mlp3_pkg::ST_ACT:
                if (r_nrn + LW'(1) < n_out)  n_state = mlp3_pkg::ST_BIAS;
                else if (r_layer == 2'd2)    n_state = mlp3_pkg::ST_RANK;
                else                         n_state = mlp3_pkg::ST_BIAS;
            mlp3_pkg::ST_RANK:
                if (r_rk == LW'(mlp3_pkg::SCORE_FIELDS - 1)) n_state = mlp3_pkg::ST_OUT;
            mlp3_pkg::ST_OUT:
                if (!r_ovalid || m_axis_tready) n_state = mlp3_pkg::ST_IDLE;
            default: n_state = mlp3_pkg::ST_IDLE;
        endcase
    end

    logic signed [15:0] rk_val;
    always_comb begin
        rk_val = (r_rk < LW'(OUTPUTS)) ? r_dst[r_rk[3:0]] : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mlp3_pkg::ST_IDLE;
            r_act    <= mlp3_pkg::ACT_LEAKY;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_act <= i_cfg_wdata;
            if (clearing) begin
                r_clr <= (r_clr[AW-1:0] == AW'(DEPTH - 1)) ? {1'b1, {AW{1'b0}}} :
                                                             r_clr + 1'b1;
            end
            r_pv <= (r_state == mlp3_pkg::ST_MAC) && (r_j != LW'(0));
            if (r_state == mlp3_pkg::ST_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mlp3_pkg::ST_IDLE: begin
                for (int k = 0; k < mlp3_pkg::FEAT_FIELDS; k++) begin
                    r_src[k] <= s_axis_tdata[22 + 16*k +: 16];
                end
                for (int k = mlp3_pkg::FEAT_FIELDS; k < MAXN; k++) begin
                    r_src[k] <= '0;
                end
                r_layer <= 2'd0;
                r_nrn   <= '0;
                r_wptr  <= '0;
            end
            mlp3_pkg::ST_BIAS: begin
                r_j <= '0;
            end
            mlp3_pkg::ST_MAC: begin
                // r_rd holds the bias on entry, a weight thereafter.
                if (r_j == LW'(0)) r_acc <= 40'(r_rd) <<< 8;
                else if (r_pv)     r_acc <= r_acc + 40'(r_prod);
                if (r_j != n_in) begin
                    r_wptr <= r_wptr + 1'b1;
                end
                r_j <= r_j + 1'b1;
            end
            mlp3_pkg::ST_ACT: begin
                r_dst[r_nrn[3:0]] <= mlp3_pkg::activate(r_act, sat);
                if (r_nrn + LW'(1) < n_out) begin
                    r_nrn <= r_nrn + 1'b1;
                end else begin
                    r_nrn <= '0;
                    if (r_layer != 2'd2) begin
                        r_layer <= r_layer + 1'b1;
                        for (int k = 0; k < MAXN; k++) begin
                            r_src[k] <= (k == int'(r_nrn)) ?
                                mlp3_pkg::activate(r_act, sat) : r_dst[k];
                        end
                    end
                    r_rk    <= '0;
                    r_best  <= '0;
                    r_bval  <= '0;
                end
            end
            mlp3_pkg::ST_RANK: begin
                if (rk_val > r_bval) begin
                    r_bval <= rk_val;
                    r_best <= r_rk[1:0];
                end
                r_rk <= r_rk + 1'b1;
            end
            default: ;
        endcase
        if (r_state == mlp3_pkg::ST_OUT && (!r_ovalid || m_axis_tready)) begin
            for (int k = 0; k < mlp3_pkg::SCORE_FIELDS; k++) begin
                r_out[16*k +: 16] <= (k < OUTPUTS) ? r_dst[k] : 16'sd0;
            end
            r_out[49:48] <= r_best;
            r_out[55:50] <= '0;
        end
    end

    // Product of the weight just read and its source value.
    always_ff @(posedge i_clk) begin
        r_prod <= r_rd * r_src[(r_j == LW'(0)) ? 4'd0 : 4'(r_j - LW'(1))];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

endmodule

FILE: rtl/core/mlp3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp3_checker
// Port-level checks on the perceptron block.
// ----------------------------------------------------------------------------
module mlp3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    // A result beat that is stalled holds its data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The class never names a fourth neuron.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:48] != 2'd3)
        else $error("class out of range");

    // After an infer beat the block stops taking items.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready during inference");
endmodule

bind mlp_three_layer_inference mlp3_checker u_mlp3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-layer perceptron block. Parameter loads
// and inference beats are streamed in under random gaps and back-pressure,
// each inference is predicted by a fixed-point model held here, and every
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STORE_WORDS = 55;
    localparam int B1_AT = 44;
    localparam int B2_AT = 48;
    localparam int B3_AT = 52;
    localparam int W2_AT = 16;
    localparam int W3_AT = 32;

    // One input beat as the bench sees it, laid out as on the bus.
    typedef struct packed {
        mlp3_pkg::t_action action;
        logic signed [15:0] f3;
        logic signed [15:0] f2;
        logic signed [15:0] f1;
        logic signed [15:0] f0;
        logic signed [15:0] value;
        logic [5:0]      index;
    } t_beat;

    // One expected result.
    typedef struct packed {
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic [1:0]         cls;
    } t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    mlp_three_layer_inference i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of the block's state: the parameter words and the mode.
    int   weights[STORE_WORDS];
    mlp3_pkg::t_act mode_now;

    t_beat  pending_beats[$];
    t_score expected_scores[$];
    int     mismatches = 0;
    int     scores_seen = 0;
    int     infer_count = 0;
    int     load_count = 0;
    bit     hold_off = 1'b0;   // the receiver is asked to stall for a long stretch
    bit     stim_done = 1'b0;

    function automatic int floor_shr(longint v, int n);
        return int'(v >>> n);  // arithmetic shift floors toward minus infinity
    endfunction

    function automatic int pwl_sigmoid(int x);
        int a, y;
        a = (x < 0) ? -x : x;
        if (a >= 1280) y = 256;
        else if (a >= 608) y = (a >>> 5) + 216;
        else if (a >= 256) y = (a >>> 3) + 160;
        else y = (a >>> 2) + 128;
        return (x < 0) ? 256 - y : y;
    endfunction

    function automatic int squash(int x);
        case (mode_now)
            mlp3_pkg::ACT_SIGMOID: return pwl_sigmoid(x);
            mlp3_pkg::ACT_TANH:    return 2 * pwl_sigmoid(2 * x) - 256;
            mlp3_pkg::ACT_RELU:    return (x > 0) ? x : 0;
            default:     return (x > 0) ? x : floor_shr(longint'(x) * 655 + 32768, 16);
        endcase
    endfunction

    // One dense layer: bias in Q16.16, sum of products, floor back to Q8.8,
    // clamp to 16 bits, then the selected activation.
    function automatic void dense(input int src[4], input int n_out, input int w_at,
                                  input int b_at, output int dst[4]);
        longint acc;
        for (int i = 0; i < 4; i++) begin
            dst[i] = 0;
            if (i < n_out) begin
                acc = longint'(weights[b_at + i]) * 256;
                for (int j = 0; j < 4; j++)
                    acc += longint'(weights[w_at + i * 4 + j]) * src[j];
                acc = acc >>> 8;
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                dst[i] = squash(int'(acc));
            end
        end
    endfunction

    // Applies one accepted beat to the bench state and queues any result.
    function automatic void forward_pass(t_beat b);
        int x[4], h1[4], h2[4], y[4];
        int best;
        t_score r;
        if (b.action == mlp3_pkg::ACTION_LOAD) begin
            if (b.index < STORE_WORDS) weights[b.index] = b.value;
            return;
        end
        x = '{b.f0, b.f1, b.f2, b.f3};
        dense(x, 4, 0, B1_AT, h1);
        dense(h1, 4, W2_AT, B2_AT, h2);
        dense(h2, 3, W3_AT, B3_AT, y);
        best = 0;
        r.cls = 2'd0;
        for (int j = 0; j < 3; j++)
            if (y[j] > best) begin
                best = y[j];
                r.cls = 2'(j);
            end
        r.s0 = 16'(y[0]);
        r.s1 = 16'(y[1]);
        r.s2 = 16'(y[2]);
        expected_scores.push_back(r);
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: offers the queued beats, with random gaps, and predicts each
    // beat as it is accepted. tvalid is only lowered when a gap is due or the
    // queue is empty, so it is never dropped and raised in the same step.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                forward_pass(t_beat'({s_axis_tuser, s_axis_tdata[85:0]}));
                send_gap = gap_len();
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    t_beat nb;
                    nb = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nb.action;
                    s_axis_tdata  <= {2'b00, nb[85:0]};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives tready with random stalls.
    int stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_score got, want;
                got.s0 = m_axis_tdata[15:0];
                got.s1 = m_axis_tdata[31:16];
                got.s2 = m_axis_tdata[47:32];
                got.cls = m_axis_tdata[49:48];
                scores_seen++;
                if (expected_scores.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat %h", m_axis_tdata);
                end else begin
                    want = expected_scores.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d expected %0d %0d %0d class %0d,",
                                      " got %0d %0d %0d class %0d"},
                                     scores_seen, want.s0, want.s1, want.s2, want.cls,
                                     got.s0, got.s1, got.s2, got.cls);
                    end
                end
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                stall = gap_len();
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_beat load_beat(int idx, int val);
        t_beat b;
        b = t_beat'(87'({$urandom, $urandom, $urandom}));
        b.action = mlp3_pkg::ACTION_LOAD;
        b.index = 6'(idx);
        b.value = 16'(val);
        return b;
    endfunction

    function automatic t_beat infer_beat(int a, int b, int c, int d);
        t_beat n;
        n = t_beat'(87'({$urandom, $urandom, $urandom}));
        n.action = mlp3_pkg::ACTION_INFER;
        n.f0 = 16'(a);
        n.f1 = 16'(b);
        n.f2 = 16'(c);
        n.f3 = 16'(d);
        return n;
    endfunction

    function automatic int small_value();
        return $urandom_range(0, 9) == 0 ? int'($urandom) : $urandom_range(0, 1023) - 512;
    endfunction

    task automatic drain();
        wait (pending_beats.size() == 0 && !s_axis_tvalid && expected_scores.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_mode(mlp3_pkg::t_act m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_now = m;
    endtask

    // Random phase: mostly whole weight sets followed by several inferences,
    // with stray loads, out-of-range indexes and extreme features mixed in.
    task automatic random_phase(int beats);
        int done;
        done = 0;
        while (done < beats) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < STORE_WORDS; k++)
                    pending_beats.push_back(load_beat(k, small_value()));
                done += STORE_WORDS;
            end
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 9) == 0)
                    pending_beats.push_back(load_beat($urandom_range(0, 63), $urandom));
                else if ($urandom_range(0, 9) == 0)
                    pending_beats.push_back(infer_beat($urandom, $urandom, $urandom, $urandom));
                else
                    pending_beats.push_back(infer_beat(small_value(), small_value(),
                                                       small_value(), small_value()));
                done++;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < STORE_WORDS; k++) weights[k] = 0;
        mode_now = mlp3_pkg::ACT_LEAKY;
        // The clearing pass after reset simply holds tready low for a while.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: zero store, extremes, saturation, ties, ignored index.
        pending_beats.push_back(infer_beat(32767, -32768, 0, 1));
        for (int k = 0; k < 16; k++) pending_beats.push_back(load_beat(k, 32767));
        pending_beats.push_back(load_beat(63, -1));
        pending_beats.push_back(load_beat(55, 12345));
        pending_beats.push_back(load_beat(B1_AT, -32768));
        pending_beats.push_back(infer_beat(32767, 32767, 32767, 32767));
        pending_beats.push_back(infer_beat(-32768, -32768, -32768, -32768));
        pending_beats.push_back(infer_beat(256, -256, 0, 0));
        drain();

        for (int m = 0; m < 4; m++) begin
            set_mode(mlp3_pkg::t_act'(m));
            random_phase(80);
            drain();
        end
        set_mode(mlp3_pkg::ACT_LEAKY);

        // Long receiver stall while the sender keeps offering beats.
        hold_off = 1'b1;
        for (int k = 0; k < 12; k++) pending_beats.push_back(infer_beat(small_value(),
            small_value(), small_value(), small_value()));
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
        drain();

        for (int p = 0; p < 8; p++) begin
            set_mode(mlp3_pkg::t_act'($urandom_range(0, 3)));
            random_phase(70);
            drain();
        end
        set_mode(mlp3_pkg::ACT_SIGMOID);
        set_mode(mlp3_pkg::ACT_LEAKY);
        random_phase(30);
        drain();
        stim_done = 1'b1;

        $display("Covered %0d inference results over all four activation modes,",
                 scores_seen);
        $display("with parameter reloads, stalls and random gaps on both sides.");
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
